// ===== design/cvg_pkg.sv =====
// Shared constants, codes and types for the chirp velocity generator.
package cvg_pkg;

   localparam int PHASE_WIDTH_DEF     = 32;
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int DUTY_WIDTH_DEF      = 12;
   localparam int TIME_WIDTH_DEF      = 20;

   localparam int INC_WIDTH       = 32;
   localparam int DURATION_WIDTH  = 20;
   localparam int SPEED_WIDTH     = 12;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam int SINE_WIDTH = 15;
   localparam logic [SINE_WIDTH-1:0] SINE_PEAK = 15'h7FFF;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_INC = 2'd0,
      CSR_SLOPE     = 2'd1,
      CSR_DURATION  = 2'd2,
      CSR_MAX_SPEED = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_STOP    = 2'd0,
      DIR_EXTEND  = 2'd1,
      DIR_RETRACT = 2'd2
   } drive_dir_type;

   // per-tick info handed from the tick controller to the duty stage
   typedef struct packed {
      logic active;    // tick is part of a running sweep
      logic negative;  // sine in quadrant 2 or 3
      logic peak;      // odd quadrant with index zero: use full-scale magnitude
   } tick_info_type;

endpackage

// ===== design/chirp_hbridge_velocity_generator.sv =====
// Top level: linear chirp velocity generator for one H-bridge actuator.
// An accepted tick reaches rsp_ through the tick/ROM register, then the result
// register. Throughput: one tick per cycle, limited by the single sine ROM read
// port; stalls only when the result is not taken.
// Reset (synchronous, active high) clears the configuration registers, the
// sweep state (idle, phase and step zero) and both pipeline valid flags.
module chirp_hbridge_velocity_generator
   import cvg_pkg::*;
#(
   parameter int PHASE_WIDTH     = PHASE_WIDTH_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int DUTY_WIDTH      = DUTY_WIDTH_DEF,
   parameter int TIME_WIDTH      = TIME_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // tick items
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_restart,
   // drive command items
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_drive_direction,
   output logic [DUTY_WIDTH-1:0]      rsp_extend_duty,
   output logic [DUTY_WIDTH-1:0]      rsp_retract_duty,
   output logic                       rsp_sweep_done,
   // register writes
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // configuration registers
   logic [INC_WIDTH-1:0]        start_inc_ff;
   logic signed [INC_WIDTH-1:0] slope_ff;
   logic [DURATION_WIDTH-1:0]   duration_ff;
   logic [SPEED_WIDTH-1:0]      max_speed_ff;

   logic                       accept;
   logic [SINE_TABLE_BITS-1:0] rom_addr;
   logic [SINE_WIDTH-1:0]      rom_data;
   tick_info_type              tick_info;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_inc_ff <= '0;
         slope_ff     <= '0;
         duration_ff  <= '0;
         max_speed_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_INC: start_inc_ff <= csr_wdata[INC_WIDTH-1:0];
            CSR_SLOPE:     slope_ff     <= signed'(csr_wdata[INC_WIDTH-1:0]);
            CSR_DURATION:  duration_ff  <= csr_wdata[DURATION_WIDTH-1:0];
            CSR_MAX_SPEED: max_speed_ff <= csr_wdata[SPEED_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // a tick advances the sweep state and launches its ROM read in the same edge
   assign accept = req_valid && req_ready;

   cvg_tick_ctrl #(
      .PHASE_WIDTH     (PHASE_WIDTH),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .TIME_WIDTH      (TIME_WIDTH)
   ) u_tick_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .restart         (req_restart),
      .start_increment (start_inc_ff),
      .increment_slope (slope_ff),
      .duration_ticks  (duration_ff),
      .rom_addr        (rom_addr),
      .tick_info       (tick_info)
   );

   cvg_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock       (clock),
      .read_enable (accept),
      .read_addr   (rom_addr),
      .read_data   (rom_data)
   );

   // scale |sine| by max speed, pick direction, hold result until taken
   cvg_duty_stage #(
      .DUTY_WIDTH (DUTY_WIDTH)
   ) u_duty_stage (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (req_valid),
      .in_ready            (req_ready),
      .tick_info           (tick_info),
      .rom_data            (rom_data),
      .max_speed           (max_speed_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_direction (rsp_drive_direction),
      .rsp_extend_duty     (rsp_extend_duty),
      .rsp_retract_duty    (rsp_retract_duty),
      .rsp_sweep_done      (rsp_sweep_done)
   );

endmodule

// ===== design/cvg_sine_rom.sv =====
// Quarter-wave sine table with registered read, built at elaboration.
module cvg_sine_rom
   import cvg_pkg::*;
#(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       read_enable,
   input  logic [SINE_TABLE_BITS-1:0] read_addr,
   output logic [SINE_WIDTH-1:0]      read_data
);

   localparam int Entries = 1 << SINE_TABLE_BITS;

   typedef logic [SINE_WIDTH-1:0] rom_array_type [Entries];

   // Q30 Taylor sine, Horner form, at x = (pi/2) * i / Entries
   function automatic rom_array_type build_table();
      rom_array_type    tbl;
      longint unsigned  x;
      longint unsigned  x2;
      longint unsigned  t;
      longint unsigned  s;
      longint unsigned  v;
      longint unsigned  one;
      one = 64'd1 << 30;
      for (int i = 0; i < Entries; i++) begin
         x  = (64'd1686629713 * longint'(i)) >> SINE_TABLE_BITS;
         x2 = (x * x) >> 30;
         t  = one - x2 / 110;
         t  = one - ((x2 * t) >> 30) / 72;
         t  = one - ((x2 * t) >> 30) / 42;
         t  = one - ((x2 * t) >> 30) / 20;
         t  = one - ((x2 * t) >> 30) / 6;
         s  = (x * t) >> 30;
         v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         tbl[i] = SINE_WIDTH'(v);
      end
      return tbl;
   endfunction

   localparam rom_array_type SineTable = build_table();

   logic [SINE_WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (read_enable) begin
         data_ff <= SineTable[read_addr];
      end
   end

   assign read_data = data_ff;

endmodule

// ===== design/cvg_tick_ctrl.sv =====
// Sweep state: tick counter, phase accumulator and chirping phase step.
module cvg_tick_ctrl
   import cvg_pkg::*;
#(
   parameter int PHASE_WIDTH     = PHASE_WIDTH_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int TIME_WIDTH      = TIME_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        restart,
   input  logic [INC_WIDTH-1:0]        start_increment,
   input  logic signed [INC_WIDTH-1:0] increment_slope,
   input  logic [DURATION_WIDTH-1:0]   duration_ticks,
   output logic [SINE_TABLE_BITS-1:0]  rom_addr,
   output tick_info_type               tick_info
);

   localparam int CmpWidth = (TIME_WIDTH > DURATION_WIDTH) ? TIME_WIDTH : DURATION_WIDTH;
   localparam int IdxLsb   = PHASE_WIDTH - 2 - SINE_TABLE_BITS;

   logic [TIME_WIDTH-1:0]  tick_count_ff, tick_count_in;
   logic [PHASE_WIDTH-1:0] phase_acc_ff, phase_acc_in;
   logic [PHASE_WIDTH-1:0] phase_step_ff, phase_step_in;
   logic                   sweeping_ff, sweeping_in;

   logic [TIME_WIDTH-1:0]      cnt;
   logic [PHASE_WIDTH-1:0]     acc;
   logic [PHASE_WIDTH-1:0]     step;
   logic [PHASE_WIDTH-1:0]     slope_ext;
   logic                       active;
   logic [1:0]                 quad;
   logic [SINE_TABLE_BITS-1:0] idx;

   // restart rewinds to time zero before this tick is evaluated
   always_comb begin
      cnt       = restart ? '0 : tick_count_ff;
      acc       = restart ? '0 : phase_acc_ff;
      step      = restart ? PHASE_WIDTH'(start_increment) : phase_step_ff;
      slope_ext = PHASE_WIDTH'(increment_slope);
      active    = (restart || sweeping_ff) &&
                  !(CmpWidth'(cnt) >= CmpWidth'(duration_ticks));

      quad = acc[PHASE_WIDTH-1 -: 2];
      idx  = acc[IdxLsb +: SINE_TABLE_BITS];

      rom_addr           = quad[0] ? (SINE_TABLE_BITS'(0) - idx) : idx;
      tick_info.active   = active;
      tick_info.negative = quad[1];
      tick_info.peak     = quad[0] && (idx == '0);

      sweeping_in = active;
      if (active) begin
         phase_acc_in  = acc + step;
         phase_step_in = step + slope_ext;
         tick_count_in = (cnt != '1) ? cnt + 1'b1 : cnt;
      end else begin
         phase_acc_in  = acc;
         phase_step_in = step;
         tick_count_in = cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         phase_acc_ff  <= '0;
         phase_step_ff <= '0;
         sweeping_ff   <= 1'b0;
      end else if (accept) begin
         tick_count_ff <= tick_count_in;
         phase_acc_ff  <= phase_acc_in;
         phase_step_ff <= phase_step_in;
         sweeping_ff   <= sweeping_in;
      end
   end

endmodule

// ===== design/cvg_duty_stage.sv =====
// Tick register and result register: magnitude scaling and drive select.
module cvg_duty_stage
   import cvg_pkg::*;
#(
   parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tick_info_type          tick_info,
   input  logic [SINE_WIDTH-1:0]  rom_data,
   input  logic [SPEED_WIDTH-1:0] max_speed,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_drive_direction,
   output logic [DUTY_WIDTH-1:0]  rsp_extend_duty,
   output logic [DUTY_WIDTH-1:0]  rsp_retract_duty,
   output logic                   rsp_sweep_done
);

   localparam int DutyMax = (1 << DUTY_WIDTH) - 1;

   logic          s1_valid_ff, s1_valid_in;
   tick_info_type info_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   drive_dir_type dir_ff, dir_in;
   logic [DUTY_WIDTH-1:0] ext_ff, ext_in;
   logic [DUTY_WIDTH-1:0] ret_ff, ret_in;
   logic                  done_ff, done_in;

   logic                              s2_load;
   logic                              accept;
   logic [SINE_WIDTH-1:0]             mag;
   logic [SPEED_WIDTH-1:0]            spd;
   logic [SINE_WIDTH+SPEED_WIDTH-1:0] prod;
   logic [SPEED_WIDTH-1:0]            q0;
   logic [SINE_WIDTH+1:0]             rem;
   logic [SPEED_WIDTH-1:0]            duty;

   assign s2_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign in_ready = !s1_valid_ff || s2_load;
   assign accept   = in_valid && in_ready;

   // prod / 32767: q0 = prod >> 15 is low by at most one
   always_comb begin
      mag  = info_ff.peak ? SINE_PEAK : rom_data;
      spd  = (int'(max_speed) > DutyMax) ? SPEED_WIDTH'(DutyMax) : max_speed;
      prod = mag * spd;
      q0   = prod[SINE_WIDTH +: SPEED_WIDTH];
      rem  = {2'b00, prod[SINE_WIDTH-1:0]} + (SINE_WIDTH+2)'(q0);
      duty = (rem >= (SINE_WIDTH+2)'(SINE_PEAK)) ? q0 + 1'b1 : q0;

      dir_in  = DIR_STOP;
      ext_in  = '0;
      ret_in  = '0;
      done_in = 1'b1;
      if (info_ff.active) begin
         done_in = 1'b0;
         if (mag != '0) begin
            if (info_ff.negative) begin
               dir_in = DIR_RETRACT;
               ret_in = DUTY_WIDTH'(duty);
            end else begin
               dir_in = DIR_EXTEND;
               ext_in = DUTY_WIDTH'(duty);
            end
         end
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= tick_info;
      end
      if (s2_load) begin
         dir_ff  <= dir_in;
         ext_ff  <= ext_in;
         ret_ff  <= ret_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_direction = dir_ff;
   assign rsp_extend_duty     = ext_ff;
   assign rsp_retract_duty    = ret_ff;
   assign rsp_sweep_done      = done_ff;

endmodule
